>>> hw/rtl/ordered_list_store_top_assert.svh
// ----------------------------------------------------------------------------
// Ordered list store assertion macros
// Shared property forms for the ordered list store. Each macro expands to a
// labeled concurrent assertion clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_STORE_TOP_ASSERT_SVH
`define ORDERED_LIST_STORE_TOP_ASSERT_SVH

// Same-cycle implication.
`define OLST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define OLST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/olst_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list store package
// Sizes, operation and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
package olst_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int MODE_W   = 2;
  localparam int POS_W    = 5;
  localparam int FOUND_W  = 4;
  localparam int ENTRY_W  = 5;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // One-hot or idle: which source a cell takes this cycle.
  typedef struct packed {
    logic load;
    logic take_prev;
    logic take_next;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/olst_cell.sv
// ----------------------------------------------------------------------------
// Ordered list store cell
// Holds one entry; loads a new value, takes its neighbor's entry on a shift,
// and compares its entry against the search key.
// ----------------------------------------------------------------------------
module olst_cell
  import olst_pkg::*;
(
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [DATA_W-1:0] prev_value,
  input  logic [DATA_W-1:0] next_value,
  input  logic [DATA_W-1:0] load_value,
  input  logic [DATA_W-1:0] key,
  output logic [DATA_W-1:0] entry,
  output logic              match
);

  logic [DATA_W-1:0] entry_next;

  always_comb begin
    entry_next = entry;
    if (ctrl.load) begin
      entry_next = load_value;
    end else if (ctrl.take_prev) begin
      entry_next = prev_value;
    end else if (ctrl.take_next) begin
      entry_next = next_value;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  assign match = (entry == key);

endmodule

>>> hw/rtl/ordered_list_store_top.sv
// ----------------------------------------------------------------------------
// Ordered list store
// Bounded ordered list of signed 32-bit entries held in a row of cells.
// Insert shifts the tail back, remove closes the gap, search reports the
// lowest matching position.
//
//   Channel   Signals                                   Handshake
//   command   mode, position, value                     start && !busy
//   result    status, removed_value, found_position,    done (one cycle)
//             entry_count
//
// The cells shift or compare in parallel at the accepting edge, and the result
// is shown in the following cycle.
// busy stays low, so a command may be issued on every cycle.
// rst (synchronous) empties the list; entry contents are left as they are.
// The receiver cannot stall; done marks each result for exactly one cycle.
// ----------------------------------------------------------------------------
module ordered_list_store_top
  import olst_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [MODE_W-1:0]         mode,
  input  logic [POS_W-1:0]          position,
  input  logic signed [DATA_W-1:0]  value,
  output logic                      done,
  output logic [STAT_W-1:0]         status,
  output logic signed [DATA_W-1:0]  removed_value,
  output logic [FOUND_W-1:0]        found_position,
  output logic [ENTRY_W-1:0]        entry_count
);

  `include "ordered_list_store_top_assert.svh"

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               accept;
  logic [CMP_W-1:0]   pos_x;
  logic [CMP_W-1:0]   cnt_x;
  logic               ins_ok;
  logic               rem_ok;
  logic [STAT_W-1:0]  status_next;
  logic [DATA_W-1:0]  removed_next;
  logic [FOUND_W-1:0] found_next;
  logic               any_match;
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] hit_vec;
  logic [DATA_W-1:0]  cell_entry [CAPACITY];
  cell_ctrl_t         cell_ctrl [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pos_x  = CMP_W'(position);
  assign cnt_x  = CMP_W'(count);
  assign ins_ok = (mode_t'(mode) == MODE_INSERT) && !(pos_x > cnt_x)
                  && (cnt_x < CMP_W'(CAPACITY));
  assign rem_ok = (mode_t'(mode) == MODE_REMOVE) && (pos_x < cnt_x);

  // Row of cells; cell k talks to k-1 and k+1.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_W-1:0] prev_v;
    logic [DATA_W-1:0] next_v;

    if (k == 0) begin : g_first
      assign prev_v = '0;
    end else begin : g_mid_p
      assign prev_v = cell_entry[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign next_v = '0;
    end else begin : g_mid_n
      assign next_v = cell_entry[k+1];
    end

    always_comb begin
      cell_ctrl[k].load      = accept && ins_ok && (pos_x == CMP_W'(k));
      cell_ctrl[k].take_prev = accept && ins_ok && (CMP_W'(k) > pos_x)
                               && !(CMP_W'(k) > cnt_x);
      cell_ctrl[k].take_next = accept && rem_ok && !(CMP_W'(k) < pos_x)
                               && ((CMP_W'(k) + CMP_W'(1)) < cnt_x);
    end

    olst_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[k]),
      .prev_value (prev_v),
      .next_value (next_v),
      .load_value (value),
      .key        (value),
      .entry      (cell_entry[k]),
      .match      (match_vec[k])
    );

    // Ignore cells past the end of the list.
    assign hit_vec[k] = match_vec[k] && (CMP_W'(k) < cnt_x);
  end

  // Lowest matching cell wins.
  always_comb begin
    found_next = '0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (hit_vec[k]) begin
        found_next = FOUND_W'(k);
      end
    end
  end

  assign any_match = |hit_vec;

  always_comb begin
    removed_next = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (rem_ok && (pos_x == CMP_W'(k))) begin
        removed_next = cell_entry[k];
      end
    end
  end

  always_comb begin
    status_next = ST_OK;
    count_next  = count;
    case (mode_t'(mode))
      MODE_INSERT: begin
        if (pos_x > cnt_x) begin
          status_next = ST_BAD_INDEX;
        end else if (!ins_ok) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      MODE_REMOVE: begin
        if (!rem_ok) begin
          status_next = ST_BAD_INDEX;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      MODE_SEARCH: begin
        status_next = any_match ? ST_OK : ST_NOT_FOUND;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  // Result word; fields not used by the operation read zero.
  always_ff @(posedge clk) begin
    if (accept) begin
      status         <= status_next;
      removed_value  <= removed_next;
      found_position <= ((mode_t'(mode) == MODE_SEARCH) && any_match) ? found_next : '0;
    end
  end

  assign entry_count = ENTRY_W'(count);

  `OLST_ASSERT_IMP(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY), "count exceeds capacity")
  `OLST_ASSERT_NXT(a_done_follows, accept, done, "accepted command gave no result")
  `OLST_ASSERT_NXT(a_no_stray_done, !accept, !done, "result without a command")
  `OLST_ASSERT_NXT(a_insert_grows, accept && ins_ok, count == $past(count) + CNT_W'(1), "insert did not grow the list")
  `OLST_ASSERT_IMP(a_err_no_removed, done && (status != ST_OK), removed_value == '0, "removed value on error")

endmodule
